>>> design/cpade_pkg.sv
// shared constants, coefficient tables and pipeline beat types for the pade cube root unit
`default_nettype none
package cpade_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int FRAC_BITS    = 30;
   localparam int ACC_FRAC     = 32;
   localparam int MAG_W        = 62;
   localparam int COEF_W       = 23;
   localparam int NUM_TERMS    = 8;
   localparam int HORNER_STEPS = NUM_TERMS - 1;
   localparam int MUL_SPLIT    = 32;
   localparam int LO_W         = DATA_WIDTH + MUL_SPLIT;
   localparam int HI_W         = DATA_WIDTH + MAG_W - MUL_SPLIT;
   localparam int PROD_W       = DATA_WIDTH + MAG_W;
   localparam int DVD_W        = MAG_W + FRAC_BITS + 1;
   localparam int DIV_CELLS    = DATA_WIDTH;

   // both sets scaled by 3^10 * 13 so every coefficient is an integer
   localparam logic [COEF_W-1:0] NUM_COEF [NUM_TERMS] = '{
      23'd767637, 23'd2814669, 23'd4113747, 23'd3047220,
      23'd1200420, 23'd240084, 23'd20748, 23'd494
   };
   localparam logic [COEF_W-1:0] DEN_COEF [NUM_TERMS] = '{
      23'd767637, 23'd2558790, 23'd3346110, 23'd2168775,
      23'd722925, 23'd115668, 23'd7140, 23'd85
   };

   // accumulators travel as sign and magnitude
   typedef struct packed {
      logic                  valid;
      logic                  tneg;
      logic [DATA_WIDTH-1:0] tmag;
      logic                  pneg;
      logic [MAG_W-1:0]      pmag;
      logic                  qneg;
      logic [MAG_W-1:0]      qmag;
   } hstep_type;

   typedef struct packed {
      logic                  valid;
      logic                  sat;
      logic                  sat_ones;
      logic [MAG_W-1:0]      rem;
      logic [DATA_WIDTH-1:0] dlo;
      logic [DATA_WIDTH-1:0] quo;
      logic [MAG_W-1:0]      divisor;
   } dstep_type;

endpackage
`default_nettype wire

>>> design/cbrt_pade_7_7_unit.sv
// top level of the (7,7) pade cube root unit: offset stage, horner cells, divider cells
`default_nettype none
// Cube root of an unsigned Q2.30 operand by the (7,7) pade approximant about one.
// A beat is taken on every clock edge with start high; busy is always low, so a
// new operand may follow every cycle and the unit sustains one result per cycle.
// Each result appears on the rsp_ ports for one cycle with rsp_valid high; the
// receiver cannot stall and none is needed. Beats pass the offset stage, the seven
// horner cells (three stages each: partial products, rounding, coefficient add),
// the divider set-up and the 32 restoring divider cells, one quotient bit per cell.
// rsp_saturated flags a non-positive denominator (all ones), a negative numerator
// (zero) or a quotient of 4.0 or more (all ones).
module cbrt_pade_7_7_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [cpade_pkg::DATA_WIDTH-1:0] req_x_value,
   output logic                             rsp_valid,
   output logic [cpade_pkg::DATA_WIDTH-1:0] rsp_cube_root,
   output logic                             rsp_saturated
);
   import cpade_pkg::*;

   localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

   // offset stage: t = x - 1 as sign and magnitude, accumulators seeded with top terms
   hstep_type             front_ff, front_in;
   hstep_type             hchain [HORNER_STEPS+1];

   // divider set-up
   hstep_type             hlast;
   logic                  p1_valid_ff, p1_valid_in;
   logic                  p1_qbad_ff, p1_qbad_in;
   logic                  p1_pbad_ff, p1_pbad_in;
   logic [DVD_W-1:0]      p1_dvd_ff, p1_dvd_in;
   logic [MAG_W-1:0]      p1_div_ff, p1_div_in;
   logic [DVD_W-DATA_WIDTH-1:0] dvd_hi;
   logic                  ovf;
   dstep_type             d0_ff, d0_in;
   dstep_type             dchain [DIV_CELLS+1];
   dstep_type             dlast;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_root_ff, rsp_root_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   always_comb begin
      front_in.valid = start;
      front_in.tneg  = req_x_value < ONE;
      front_in.tmag  = front_in.tneg ? ONE - req_x_value : req_x_value - ONE;
      front_in.pneg  = 1'b0;
      front_in.pmag  = MAG_W'({NUM_COEF[HORNER_STEPS], ACC_FRAC'(0)});
      front_in.qneg  = 1'b0;
      front_in.qmag  = MAG_W'({DEN_COEF[HORNER_STEPS], ACC_FRAC'(0)});
   end

   assign hchain[0] = front_ff;

   // horner cells, highest coefficient first
   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
      cpade_horner_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .num_coef (NUM_COEF[HORNER_STEPS-1-i]),
         .den_coef (DEN_COEF[HORNER_STEPS-1-i]),
         .step_in  (hchain[i]),
         .step_out (hchain[i+1])
      );
   end

   assign hlast = hchain[HORNER_STEPS];

   // dividend p * 2^frac + floor(q / 2) gives round to nearest, ties up
   always_comb begin
      p1_valid_in = hlast.valid;
      p1_qbad_in  = hlast.qneg || (hlast.qmag == '0);
      p1_pbad_in  = hlast.pneg;
      p1_dvd_in   = DVD_W'({hlast.pmag, FRAC_BITS'(0)}) + DVD_W'(hlast.qmag >> 1);
      p1_div_in   = hlast.qmag;
   end

   // quotient reaches 2^32 when the upper dividend bits alone are not below q;
   // otherwise those bits are the starting remainder
   always_comb begin
      dvd_hi         = p1_dvd_ff[DVD_W-1:DATA_WIDTH];
      ovf            = MAG_W'(dvd_hi) >= p1_div_ff;
      d0_in.valid    = p1_valid_ff;
      d0_in.sat      = p1_qbad_ff || p1_pbad_ff || ovf;
      d0_in.sat_ones = p1_qbad_ff || (!p1_pbad_ff && ovf);
      d0_in.rem      = MAG_W'(dvd_hi);
      d0_in.dlo      = p1_dvd_ff[DATA_WIDTH-1:0];
      d0_in.quo      = '0;
      d0_in.divisor  = p1_div_ff;
   end

   assign dchain[0] = d0_ff;

   for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
      cpade_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step_in  (dchain[j]),
         .step_out (dchain[j+1])
      );
   end

   assign dlast = dchain[DIV_CELLS];

   // saturated beats take a limit value, others the quotient
   always_comb begin
      rsp_valid_in = dlast.valid;
      rsp_sat_in   = dlast.sat;
      if (dlast.sat) begin
         rsp_root_in = dlast.sat_ones ? '1 : '0;
      end else begin
         rsp_root_in = dlast.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
         p1_valid_ff    <= 1'b0;
         d0_ff.valid    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         front_ff     <= front_in;
         p1_valid_ff  <= p1_valid_in;
         d0_ff        <= d0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p1_qbad_ff  <= p1_qbad_in;
      p1_pbad_ff  <= p1_pbad_in;
      p1_dvd_ff   <= p1_dvd_in;
      p1_div_ff   <= p1_div_in;
      rsp_root_ff <= rsp_root_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // fully pipelined: never refuses a beat
   assign busy          = 1'b0;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cube_root = rsp_root_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   // divider start must hold a remainder below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      d0_ff.valid && !d0_ff.sat |-> d0_ff.rem < d0_ff.divisor)
      else $error("divider start remainder not below divisor");

   // every beat entering the divider comes out after the divider cells
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      d0_ff.valid |-> ##(DIV_CELLS+1) rsp_valid)
      else $error("divider beat lost");

   // a saturated result is one of the two limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_cube_root == '0 || rsp_cube_root == '1))
      else $error("saturated result not at a limit");
`endif

endmodule
`default_nettype wire

>>> design/cpade_horner_cell.sv
// one horner step for numerator and denominator: multiply, round, add coefficient
`default_nettype none
module cpade_horner_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cpade_pkg::COEF_W-1:0]   num_coef,
   input  logic [cpade_pkg::COEF_W-1:0]   den_coef,
   input  cpade_pkg::hstep_type           step_in,
   output cpade_pkg::hstep_type           step_out
);
   import cpade_pkg::*;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   // stage 1: partial products
   logic                  v1_ff, v1_in;
   logic                  tneg1_ff, tneg1_in;
   logic [DATA_WIDTH-1:0] tmag1_ff, tmag1_in;
   logic [LO_W-1:0]       lo1_ff [2];
   logic [LO_W-1:0]       lo1_in [2];
   logic [HI_W-1:0]       hi1_ff [2];
   logic [HI_W-1:0]       hi1_in [2];
   logic                  sgn1_ff [2];
   logic                  sgn1_in [2];

   // stage 2: rounded magnitude
   logic                  v2_ff, v2_in;
   logic                  tneg2_ff, tneg2_in;
   logic [DATA_WIDTH-1:0] tmag2_ff, tmag2_in;
   logic [MAG_W-1:0]      mag2_ff [2];
   logic [MAG_W-1:0]      mag2_in [2];
   logic                  sgn2_ff [2];
   logic                  sgn2_in [2];

   // stage 3: add coefficient
   hstep_type             out_ff, out_in;

   logic [MAG_W-1:0]      amag [2];
   logic                  aneg [2];
   logic [PROD_W-1:0]     sum [2];
   logic [COEF_W-1:0]     coef [2];
   logic [MAG_W-1:0]      cval [2];
   logic [MAG_W:0]        diff [2];
   logic [MAG_W-1:0]      rmag [2];
   logic                  rneg [2];

   always_comb begin
      amag[0] = step_in.pmag;
      aneg[0] = step_in.pneg;
      amag[1] = step_in.qmag;
      aneg[1] = step_in.qneg;
      coef[0] = num_coef;
      coef[1] = den_coef;
      v1_in    = step_in.valid;
      tneg1_in = step_in.tneg;
      tmag1_in = step_in.tmag;
      v2_in    = v1_ff;
      tneg2_in = tneg1_ff;
      tmag2_in = tmag1_ff;
      for (int l = 0; l < 2; l++) begin
         lo1_in[l]  = LO_W'(step_in.tmag) * LO_W'(amag[l][MUL_SPLIT-1:0]);
         hi1_in[l]  = HI_W'(step_in.tmag) * HI_W'(amag[l][MAG_W-1:MUL_SPLIT]);
         sgn1_in[l] = step_in.tneg ^ aneg[l];
         sum[l]     = PROD_W'(lo1_ff[l]) + {hi1_ff[l], MUL_SPLIT'(0)} + ROUND_HALF;
         mag2_in[l] = sum[l][FRAC_BITS +: MAG_W];
         sgn2_in[l] = sgn1_ff[l];
         cval[l]    = MAG_W'({coef[l], ACC_FRAC'(0)});
         diff[l]    = {1'b0, cval[l]} - {1'b0, mag2_ff[l]};
         if (!sgn2_ff[l]) begin
            rmag[l] = cval[l] + mag2_ff[l];
            rneg[l] = 1'b0;
         end else if (diff[l][MAG_W]) begin
            rmag[l] = mag2_ff[l] - cval[l];
            rneg[l] = 1'b1;
         end else begin
            rmag[l] = diff[l][MAG_W-1:0];
            rneg[l] = 1'b0;
         end
      end
      out_in.valid = v2_ff;
      out_in.tneg  = tneg2_ff;
      out_in.tmag  = tmag2_ff;
      out_in.pmag  = rmag[0];
      out_in.pneg  = rneg[0];
      out_in.qmag  = rmag[1];
      out_in.qneg  = rneg[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         out_ff <= out_in;
      end
      tneg1_ff <= tneg1_in;
      tmag1_ff <= tmag1_in;
      tneg2_ff <= tneg2_in;
      tmag2_ff <= tmag2_in;
      for (int l = 0; l < 2; l++) begin
         lo1_ff[l]  <= lo1_in[l];
         hi1_ff[l]  <= hi1_in[l];
         sgn1_ff[l] <= sgn1_in[l];
         mag2_ff[l] <= mag2_in[l];
         sgn2_ff[l] <= sgn2_in[l];
      end
   end

   assign step_out = out_ff;

endmodule
`default_nettype wire

>>> design/cpade_div_cell.sv
// one restoring division step: one quotient bit per cell
`default_nettype none
module cpade_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  cpade_pkg::dstep_type step_in,
   output cpade_pkg::dstep_type step_out
);
   import cpade_pkg::*;

   dstep_type        step_ff, step_in_d;
   logic [MAG_W:0]   trial;
   logic [MAG_W+1:0] diff;
   logic             take;

   always_comb begin
      trial     = {step_in.rem, step_in.dlo[DATA_WIDTH-1]};
      diff      = {1'b0, trial} - {2'b00, step_in.divisor};
      take      = !diff[MAG_W+1];
      step_in_d = step_in;
      step_in_d.rem = take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      step_in_d.dlo = {step_in.dlo[DATA_WIDTH-2:0], 1'b0};
      step_in_d.quo = {step_in.quo[DATA_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else begin
         step_ff <= step_in_d;
      end
   end

   assign step_out = step_ff;

endmodule
`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the pade cube root unit: directed and random operand streams
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   localparam int W     = cpade_pkg::DATA_WIDTH;
   localparam int FB    = cpade_pkg::FRAC_BITS;
   localparam int AF    = 32;
   // clamp level for the horner accumulators and rounded products
   localparam longint ACC_LIMIT = 64'sd1 << 62;
   // drain allowance after the last expected result, longer than the unit's latency
   localparam int DRAIN_CYCLES = 80;
   localparam int END_WAIT_MAX = 2000;

   // coefficient tables, both scaled by the same integer so they are exact
   localparam longint NUMER_C [8] = '{767637, 2814669, 4113747, 3047220,
                                      1200420, 240084, 20748, 494};
   localparam longint DENOM_C [8] = '{767637, 2558790, 3346110, 2168775,
                                      722925, 115668, 7140, 85};

   typedef struct packed {
      logic [W-1:0] root;
      logic         sat;
   } root_beat_t;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic [W-1:0] req_x_value;
   logic         rsp_valid;
   logic [W-1:0] rsp_cube_root;
   logic         rsp_saturated;

   root_beat_t pending_roots[$];
   int         error_count;
   // when set the sender never inserts gaps
   bit         no_gaps;

   cbrt_pade_7_7_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_x_value   (req_x_value),
      .rsp_valid     (rsp_valid),
      .rsp_cube_root (rsp_cube_root),
      .rsp_saturated (rsp_saturated)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // one horner evaluation: acc = c_k * 2^32 + round(t * acc / 2^30), ties away from zero
   function automatic longint horner_eval(input longint coef [8], input logic [63:0] tmag,
                                          input bit tneg, inout bit sat);
      longint      acc;
      longint      prod;
      logic [63:0] amag;
      logic [127:0] pr;
      bit          aneg;
      acc = coef[7] <<< AF;
      for (int k = 6; k >= 0; k--) begin
         aneg = acc < 0;
         amag = aneg ? -acc : acc;
         pr = {64'd0, tmag} * {64'd0, amag};
         pr = (pr + (128'd1 << (FB - 1))) >> FB;
         // rounded product beyond the limit is clamped
         if (pr > 128'(ACC_LIMIT)) begin
            sat = 1'b1;
            pr = 128'(ACC_LIMIT);
         end
         prod = (tneg != aneg) ? -longint'(pr[63:0]) : longint'(pr[63:0]);
         acc = (coef[k] <<< AF) + prod;
         if (acc > ACC_LIMIT) begin
            sat = 1'b1;
            acc = ACC_LIMIT;
         end else if (acc < -ACC_LIMIT) begin
            sat = 1'b1;
            acc = -ACC_LIMIT;
         end
      end
      return acc;
   endfunction

   // expected root beat for one operand
   function automatic root_beat_t cube_root_expect(input logic [W-1:0] x);
      root_beat_t   r;
      logic [63:0]  one;
      logic [63:0]  tmag;
      bit           tneg;
      bit           sat;
      longint       p;
      longint       q;
      logic [127:0] dv;
      logic [127:0] quo;
      one  = 64'd1 << FB;
      tneg = {32'd0, x} < one;
      tmag = tneg ? one - {32'd0, x} : {32'd0, x} - one;
      sat  = 1'b0;
      p = horner_eval(NUMER_C, tmag, tneg, sat);
      q = horner_eval(DENOM_C, tmag, tneg, sat);
      if (q <= 0) begin
         r.root = '1;
         sat = 1'b1;
      end else if (p < 0) begin
         r.root = '0;
         sat = 1'b1;
      end else begin
         // quotient rounded to nearest, ties up
         dv  = ({64'd0, p} << FB) + {64'd0, q >> 1};
         quo = dv / {64'd0, q};
         if (quo > 128'({W{1'b1}})) begin
            r.root = '1;
            sat = 1'b1;
         end else begin
            r.root = quo[W-1:0];
         end
      end
      r.sat = sat;
      return r;
   endfunction

   // present one operand and hold it until the unit takes the beat
   task automatic send_operand(input logic [W-1:0] x);
      start       <= 1'b1;
      req_x_value <= x;
      do @(posedge clock); while (busy);
      pending_roots.push_back(cube_root_expect(x));
   endtask

   // random gap before the next beat, possibly none; each idle cycle is added with odds of about 11 in 100
   task automatic maybe_gap();
      while (!no_gaps && $urandom_range(99) < 11) begin
         start       <= 1'b0;
         req_x_value <= $urandom;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_roots.size() != 0) @(posedge clock);
   endtask

   // random operand weighted toward the interesting regions
   function automatic logic [W-1:0] pick_operand();
      logic [W-1:0] v;
      case ($urandom_range(5))
         0: v = $urandom_range(255);
         1: v = $urandom_range(32'h4000_0100, 32'h3FFF_FF00);
         2: v = 32'hFFFF_FFFF - $urandom_range(255);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // field extremes, the unit point and the integer points
   task automatic test_directed();
      logic [W-1:0] points [] = '{32'h0000_0000, 32'h0000_0001, 32'h3FFF_FFFF,
                                  32'h4000_0000, 32'h4000_0001, 32'h2000_0000,
                                  32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
                                  32'h0800_0000, 32'h1000_0000, 32'h7FFF_FFFF,
                                  32'h0000_FFFF, 32'hFFFF_0000};
      foreach (points[i]) begin
         maybe_gap();
         send_operand(points[i]);
      end
   endtask

   // back-to-back beats on every cycle
   task automatic test_full_rate(input int count);
      no_gaps = 1'b1;
      repeat (count) send_operand(pick_operand());
      no_gaps = 1'b0;
   endtask

   // random beats with random gaps
   task automatic test_random_gaps(input int count);
      repeat (count) begin
         maybe_gap();
         send_operand(pick_operand());
      end
   endtask

   // sender holds off until the pipe is empty, then resumes
   task automatic test_drain_pause(input int count);
      test_random_gaps(count);
      wait_for_drain();
      test_random_gaps(count);
   endtask

   // every strobed beat is checked against the oldest expected root
   always @(posedge clock) begin
      root_beat_t want;
      if (!reset && rsp_valid) begin
         if (pending_roots.size() == 0) begin
            $display("%0t: unexpected root beat %h sat %b", $time, rsp_cube_root,
                     rsp_saturated);
            error_count++;
         end else begin
            want = pending_roots.pop_front();
            if (rsp_cube_root !== want.root) begin
               $display("%0t: cube_root expected %h actual %h", $time, want.root,
                        rsp_cube_root);
               error_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t: saturated expected %b actual %b", $time, want.sat,
                        rsp_saturated);
               error_count++;
            end
         end
      end
   end

   initial begin
      int waited;
      error_count = 0;
      no_gaps     = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_x_value = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_rate(250);
      test_random_gaps(250);
      test_drain_pause(140);
      test_full_rate(20);
      test_random_gaps(130);

      // let the pipe empty out, bounded
      start <= 1'b0;
      waited = 0;
      while (pending_roots.size() != 0 && waited < END_WAIT_MAX) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_roots.size() != 0) begin
         $display("%0t: %0d expected root beats never arrived", $time,
                  pending_roots.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #400000;
      $display("testbench failed");
      $finish;
   end

endmodule
`default_nettype wire
